// File: src/dirty_rect_merge_table_assert.svh
// ---------------------------------------------------------------------------
// Dirty rectangle merge table assertion macros
// Concurrent assertion wrappers clocked by clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DIRTY_RECT_MERGE_TABLE_ASSERT_SVH
`define DIRTY_RECT_MERGE_TABLE_ASSERT_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define DRMT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
// Implication checked in the same cycle.
`define DRMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define DRMT_ASSERT_ALWAYS(lbl, cond, msg)
`define DRMT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: src/drmt_pkg.sv
// ---------------------------------------------------------------------------
// Dirty rectangle merge table package
// Payload types, command encodings and scaling constants.
// ---------------------------------------------------------------------------
package drmt_pkg;

  // Virtual to screen scaling.
  localparam int SCALE      = 2;
  localparam int WIDTH_UNIT = 4;
  localparam int W_MULT     = WIDTH_UNIT * SCALE;

  // Field widths.
  localparam int X_W      = 11;
  localparam int Y_W      = 10;
  localparam int W_W      = 11;
  localparam int H_W      = 10;
  localparam int SLOT_W   = 5;
  localparam int KIND_W   = 3;
  localparam int OFFSET_W = 8;
  localparam int DEST_W   = 11;

  // Input mode codes.
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Result kind codes.
  localparam logic [KIND_W-1:0] KIND_APPEND      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MERGED      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COPY        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH_EMPTY = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [8:0] virt_x;
    logic [7:0] virt_y;
    logic [6:0] virt_w;
    logic [7:0] virt_h;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [X_W-1:0]    rect_x;
    logic [Y_W-1:0]    rect_y;
    logic [DEST_W-1:0] dest_y;
    logic [W_W-1:0]    rect_w;
    logic [H_W-1:0]    rect_h;
    logic              last;
  } res_item_t;

  // One rectangle in screen pixels.
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [W_W-1:0] w;
    logic [H_W-1:0] h;
  } rect_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic  mode;
    rect_t rect;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE,
    ST_FLUSH
  } back_state_t;

endpackage

// File: src/dirty_rect_merge_table.sv
// An add transaction passes through ST_LOOK and ST_UPDATE once the engine has taken it
// from the command queue; an idle engine takes it in ST_IDLE first. ST_LOOK compares
// the scaled rectangle against every pending entry in parallel and picks the first one
// that overlaps or touches it. ST_UPDATE, once the result register is free, writes the
// merged or appended entry and loads the result register. A flush walks the pending
// entries in order through the single read port of the table, one result per entry
// (one empty-flush result for an empty table). While the engine works or a result waits
// to be taken, the front stage and a two-entry command queue keep accepting input
// transactions until they fill. dest_row_offset is taken from cfg_wdata on cfg_we.
`include "dirty_rect_merge_table_assert.svh"
// ---------------------------------------------------------------------------
// Dirty rectangle merge table
// Top level: front end, command queue, table engine and offset register.
// ---------------------------------------------------------------------------
module dirty_rect_merge_table #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  drmt_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output drmt_pkg::res_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [drmt_pkg::OFFSET_W-1:0] cfg_wdata
);
  import drmt_pkg::*;

  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  logic                front_valid, front_ready;
  cmd_t                front_cmd;
  logic                q_valid, q_ready;
  cmd_t                q_cmd;
  logic [OFFSET_W-1:0] offset_r;
  logic [CNT_W-1:0]    pend_count;

  // Destination row offset register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_we) begin
      offset_r <= cfg_wdata;
    end
  end

  drmt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd_data  (front_cmd)
  );

  drmt_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  drmt_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_data   (q_cmd),
    .row_offset (offset_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .pend_count (pend_count)
  );

  // The pending count never passes the table depth.
  `DRMT_ASSERT_ALWAYS(a_count_bound, pend_count <= CNT_W'(PENDING_DEPTH), "pending count overflow")
  // The final copy of a flush leaves the table empty.
  `DRMT_ASSERT_IMP(a_flush_empties, out_valid && out_data.kind == KIND_COPY && out_data.last, pend_count == '0, "flush did not empty table")
  // A drop is only reported while the table is full.
  `DRMT_ASSERT_IMP(a_drop_full, out_valid && out_data.kind == KIND_DROPPED, pend_count == CNT_W'(PENDING_DEPTH), "drop with free slot")

endmodule

// File: src/drmt_front.sv
// ---------------------------------------------------------------------------
// Dirty rectangle merge table front end
// Accepts input transactions, scales them to screen pixels and stages them.
// ---------------------------------------------------------------------------
module drmt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  drmt_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output drmt_pkg::cmd_t     cmd_data
);
  import drmt_pkg::*;

  logic stg_valid_r, stg_valid_nxt;
  cmd_t stg_r, stg_nxt;
  logic accept;

  assign in_ready = !stg_valid_r || cmd_ready;
  assign accept   = in_valid && in_ready;

  // Scale the incoming rectangle and keep the mode as the command class.
  always_comb begin
    stg_nxt.mode   = in_data.mode;
    stg_nxt.rect.x = X_W'(in_data.virt_x) * X_W'(SCALE);
    stg_nxt.rect.y = Y_W'(in_data.virt_y) * Y_W'(SCALE);
    stg_nxt.rect.w = W_W'(in_data.virt_w) * W_W'(W_MULT);
    stg_nxt.rect.h = H_W'(in_data.virt_h) * H_W'(SCALE);
  end

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= stg_nxt;
    end
  end

  assign cmd_valid = stg_valid_r;
  assign cmd_data  = stg_r;

endmodule

// File: src/drmt_cmd_fifo.sv
// ---------------------------------------------------------------------------
// Dirty rectangle merge table command queue
// Two-entry queue that decouples the front end from the table engine.
// ---------------------------------------------------------------------------
module drmt_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  drmt_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output drmt_pkg::cmd_t pop_data
);
  import drmt_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       mem_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign push_ready = fill_r != 2'(DEPTH);
  assign pop_valid  = fill_r != 2'd0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/drmt_back.sv
// ---------------------------------------------------------------------------
// Dirty rectangle merge table engine
// Holds the pending table, compares all entries in parallel, merges,
// appends or drops, walks the table on flush and drives the result register.
// ---------------------------------------------------------------------------
module drmt_back #(
  parameter int PENDING_DEPTH = 32,
  parameter int IDX_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
  parameter int CNT_W         = $clog2(PENDING_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  drmt_pkg::cmd_t                     cmd_data,
  input  logic [drmt_pkg::OFFSET_W-1:0]      row_offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output drmt_pkg::res_item_t                out_data,
  output logic [CNT_W-1:0]                   pend_count
);
  import drmt_pkg::*;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  flush_idx_r, flush_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  rect_t             rects_r [PENDING_DEPTH];
  res_item_t         out_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic                     out_free;
  logic                     emit;
  logic                     pop;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  rect_t                    wr_rect;
  logic [IDX_W-1:0]         rd_idx;
  rect_t                    rd_rect;
  rect_t                    union_rect;
  logic [PENDING_DEPTH-1:0] hit_vec;
  logic [IDX_W-1:0]         first_idx;
  logic                     table_full;
  logic                     flush_is_last;
  logic                     flush_done;

  // Build one result item; dest_y is the rectangle y plus the configured row offset.
  function automatic res_item_t make_res(input logic [KIND_W-1:0] kind,
                                         input logic [SLOT_W-1:0] slot,
                                         input rect_t r,
                                         input logic [OFFSET_W-1:0] offs,
                                         input logic last);
    res_item_t res;
    res.kind   = kind;
    res.slot   = slot;
    res.rect_x = r.x;
    res.rect_y = r.y;
    res.dest_y = DEST_W'(r.y) + DEST_W'(offs);
    res.rect_w = r.w;
    res.rect_h = r.h;
    res.last   = last;
    return res;
  endfunction

  // Slot numbers are reported modulo two to the power of the slot field width.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  assign out_free   = !out_valid_r || out_ready;
  assign table_full = count_r == CNT_W'(PENDING_DEPTH);

  // Parallel closed-edge overlap test of every valid entry against the command.
  always_comb begin
    logic [X_W:0] n_x2, e_x2;
    logic [Y_W:0] n_y2, e_y2;
    n_x2 = {1'b0, cmd_r.rect.x} + {1'b0, cmd_r.rect.w};
    n_y2 = {1'b0, cmd_r.rect.y} + {1'b0, cmd_r.rect.h};
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      e_x2 = {1'b0, rects_r[i].x} + {1'b0, rects_r[i].w};
      e_y2 = {1'b0, rects_r[i].y} + {1'b0, rects_r[i].h};
      hit_vec[i] = (CNT_W'(i) < count_r) &&
                   ({1'b0, rects_r[i].x} <= n_x2) &&
                   (e_x2 >= {1'b0, cmd_r.rect.x}) &&
                   ({1'b0, rects_r[i].y} <= n_y2) &&
                   (e_y2 >= {1'b0, cmd_r.rect.y});
    end
  end

  // First hitting entry in table order.
  always_comb begin
    first_idx = '0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  // Single table read port, shared by merge and flush.
  assign rd_idx  = (state_r == ST_FLUSH) ? flush_idx_r : hit_idx_r;
  assign rd_rect = rects_r[rd_idx];

  // Bounding union of the hit entry and the command, saturated to field range.
  always_comb begin
    logic [X_W:0] x1, ax2, bx2, x2, w;
    logic [Y_W:0] y1, ay2, by2, y2, h;
    x1  = (rd_rect.x < cmd_r.rect.x) ? {1'b0, rd_rect.x} : {1'b0, cmd_r.rect.x};
    y1  = (rd_rect.y < cmd_r.rect.y) ? {1'b0, rd_rect.y} : {1'b0, cmd_r.rect.y};
    ax2 = {1'b0, rd_rect.x} + {1'b0, rd_rect.w};
    bx2 = {1'b0, cmd_r.rect.x} + {1'b0, cmd_r.rect.w};
    ay2 = {1'b0, rd_rect.y} + {1'b0, rd_rect.h};
    by2 = {1'b0, cmd_r.rect.y} + {1'b0, cmd_r.rect.h};
    x2  = (ax2 > bx2) ? ax2 : bx2;
    y2  = (ay2 > by2) ? ay2 : by2;
    w   = x2 - x1;
    h   = y2 - y1;
    union_rect.x = x1[X_W-1:0];
    union_rect.y = y1[Y_W-1:0];
    union_rect.w = w[W_W] ? {W_W{1'b1}} : w[W_W-1:0];
    union_rect.h = h[H_W] ? {H_W{1'b1}} : h[H_W-1:0];
  end

  // Flush walk position.
  assign flush_is_last = (CNT_W'(flush_idx_r) + CNT_W'(1)) == count_r;
  assign flush_done    = (count_r == '0) || flush_is_last;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd_data.mode == MODE_FLUSH) ? ST_FLUSH : ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE, ST_FLUSH: begin
        if (out_free && (state_r == ST_UPDATE || flush_done)) begin
          if (cmd_valid) begin
            state_nxt = (cmd_data.mode == MODE_FLUSH) ? ST_FLUSH : ST_LOOK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs: table updates, result generation and queue pops.
  always_comb begin
    pop           = 1'b0;
    emit          = 1'b0;
    res_nxt       = '0;
    wr_en         = 1'b0;
    wr_idx        = hit_idx_r;
    wr_rect       = union_rect;
    count_nxt     = count_r;
    flush_idx_nxt = flush_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    case (state_r)
      ST_IDLE: begin
        pop = cmd_valid;
      end
      ST_LOOK: begin
        hit_nxt     = |hit_vec;
        hit_idx_nxt = first_idx;
      end
      ST_UPDATE: begin
        if (out_free) begin
          emit = 1'b1;
          pop  = cmd_valid;
          if (hit_r) begin
            wr_en   = 1'b1;
            res_nxt = make_res(KIND_MERGED, slot_of(hit_idx_r), union_rect,
                               row_offset, 1'b1);
          end else if (table_full) begin
            res_nxt = make_res(KIND_DROPPED, '0, cmd_r.rect, row_offset, 1'b1);
          end else begin
            wr_en     = 1'b1;
            wr_idx    = count_r[IDX_W-1:0];
            wr_rect   = cmd_r.rect;
            count_nxt = count_r + CNT_W'(1);
            res_nxt   = make_res(KIND_APPEND, slot_of(count_r[IDX_W-1:0]),
                                 cmd_r.rect, row_offset, 1'b1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (count_r == '0) begin
            res_nxt      = '0;
            res_nxt.kind = KIND_FLUSH_EMPTY;
            res_nxt.last = 1'b1;
            pop          = cmd_valid;
          end else begin
            res_nxt = make_res(KIND_COPY, slot_of(flush_idx_r), rd_rect,
                               row_offset, flush_is_last);
            flush_idx_nxt = flush_idx_r + IDX_W'(1);
            if (flush_is_last) begin
              count_nxt = '0;
              pop       = cmd_valid;
            end
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    if (pop) begin
      flush_idx_nxt = '0;
    end
  end

  assign cmd_nxt       = pop ? cmd_data : cmd_r;
  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      flush_idx_r <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flush_idx_r <= flush_idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    hit_idx_r <= hit_idx_nxt;
    if (emit) begin
      out_r <= res_nxt;
    end
  end

  // Pending rectangle table.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rects_r[wr_idx] <= wr_rect;
    end
  end

  assign cmd_ready  = pop;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign pend_count = count_r;

endmodule
